// ----- rtl/dda_pkg.sv -----
// Shared types and constants for the styled DDA line generator.
// Used by dda_dp, dda_ctrl and the top under rtl/ (not dda_div); depends on nothing.
package dda_pkg;

	localparam int COORD_BITS    = 10;
	localparam int FRAC_BITS_DEF = 16;
	localparam int PIX_W         = 12;
	localparam int IDX_W         = 4;

	localparam logic [IDX_W-1:0] THICK_LAST = IDX_W'(8);

	typedef enum logic {
		ACT_START   = 1'b0,
		ACT_ADVANCE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STYLE_SIMPLE = 2'd0,
		STYLE_DOTTED = 2'd1,
		STYLE_DASHED = 2'd2,
		STYLE_THICK  = 2'd3
	} style_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic                  action;
		logic [COORD_BITS-1:0] start_x;
		logic [COORD_BITS-1:0] start_y;
		logic [COORD_BITS-1:0] end_x;
		logic [COORD_BITS-1:0] end_y;
	} in_item_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_x;
		logic signed [PIX_W-1:0] pixel_y;
		logic                    last;
		logic                    line_done;
	} out_item_t;

	typedef struct packed {
		logic             load_start;
		logic             step_adv;
		logic             out_load;
		logic [IDX_W-1:0] pix_idx;
		logic             pix_last;
	} dda_cmd_t;

	typedef struct packed {
		logic busy;
		logic start_zero;
		logic adv_emit;
		logic adv_thick;
		logic div_busy;
		logic out_free;
	} dda_stat_t;

	// Thick pattern: (0,0) (+1,0) (-1,0) (0,+1) (0,-1) (-1,+1) (-1,-1) (+1,+1) (+1,-1)
	function automatic logic signed [1:0] thick_dx(input logic [IDX_W-1:0] idx);
		logic signed [1:0] r;
		case (idx)
			4'd1, 4'd7, 4'd8: r = 2'sd1;
			4'd2, 4'd5, 4'd6: r = -2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] thick_dy(input logic [IDX_W-1:0] idx);
		logic signed [1:0] r;
		case (idx)
			4'd3, 4'd5, 4'd7: r = 2'sd1;
			4'd4, 4'd6, 4'd8: r = -2'sd1;
			default:          r = 2'sd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/dda_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by dda_dp for the per-axis increments.
module dda_div #(
	parameter int DVD_W = 26,
	parameter int DVS_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = ~diff[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

// ----- rtl/dda_dp.sv -----
// Datapath: line state, position accumulators, increment dividers, style logic
// and the output register. Depends on dda_pkg and dda_div.
module dda_dp import dda_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  in_item_t  req,
	input  dda_cmd_t  cmd,
	output dda_stat_t stat,
	input  logic      pix_stall,
	output logic      pix_valid,
	output out_item_t pix
);

	localparam int POS_W = COORD_BITS + FRAC_BITS + 1;
	localparam int INC_W = FRAC_BITS + 2;
	localparam int DVD_W = COORD_BITS + FRAC_BITS;
	localparam int SUM_W = (COORD_BITS + 2 > PIX_W) ? COORD_BITS + 2 : PIX_W;

	logic [1:0]            style_q;
	logic [POS_W-1:0]      pos_x_q, pos_y_q;
	logic [COORD_BITS-1:0] steps_left_q;
	logic [1:0]            dash_count_q;
	logic                  dash_off_q;
	logic                  busy_q;
	logic                  sign_x_q, sign_y_q;
	logic                  done_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	// Start geometry
	logic [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS-1:0] ax, ay, steps;
	logic                  div_start;
	logic                  busy_x, busy_y;
	logic [DVD_W-1:0]      quo_x, quo_y;
	logic [INC_W-1:0]      inc_x, inc_y;

	assign dx = {1'b0, req.end_x} - {1'b0, req.start_x};
	assign dy = {1'b0, req.end_y} - {1'b0, req.start_y};

	always_comb begin
		logic [COORD_BITS:0] nx, ny;
		nx    = -dx;
		ny    = -dy;
		ax    = dx[COORD_BITS] ? nx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
		ay    = dy[COORD_BITS] ? ny[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
		steps = (ax > ay) ? ax : ay;
	end

	assign div_start = cmd.load_start & (steps != '0);

	dda_div #(.DVD_W(DVD_W), .DVS_W(COORD_BITS)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({ax, {FRAC_BITS{1'b0}}}),
		.divisor  (steps),
		.busy     (busy_x),
		.quotient (quo_x)
	);

	dda_div #(.DVD_W(DVD_W), .DVS_W(COORD_BITS)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({ay, {FRAC_BITS{1'b0}}}),
		.divisor  (steps),
		.busy     (busy_y),
		.quotient (quo_y)
	);

	// Quotient never exceeds 1.0, so FRAC_BITS+1 bits hold it
	always_comb begin
		logic [INC_W-1:0] mx, my;
		mx    = {1'b0, quo_x[FRAC_BITS:0]};
		my    = {1'b0, quo_y[FRAC_BITS:0]};
		inc_x = sign_x_q ? -mx : mx;
		inc_y = sign_y_q ? -my : my;
	end

	// Advance decision
	logic fin, third;
	logic adv_emit, adv_thick;
	assign fin   = (steps_left_q == COORD_BITS'(1));
	assign third = (dash_count_q == 2'd2);

	always_comb begin
		adv_thick = 1'b0;
		case (style_t'(style_q))
			STYLE_SIMPLE: adv_emit = 1'b1;
			STYLE_DOTTED: adv_emit = third | fin;
			STYLE_DASHED: adv_emit = ~dash_off_q | fin;
			STYLE_THICK: begin
				adv_emit  = 1'b1;
				adv_thick = 1'b1;
			end
			default:      adv_emit = 1'b1;
		endcase
	end

	assign stat.adv_emit   = adv_emit;
	assign stat.adv_thick  = adv_thick;
	assign stat.busy       = busy_q;
	assign stat.start_zero = (steps == '0);
	assign stat.div_busy   = busy_x | busy_y;
	assign stat.out_free   = ~out_valid_q | ~pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			style_q      <= STYLE_SIMPLE;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			steps_left_q <= '0;
			dash_count_q <= '0;
			dash_off_q   <= 1'b0;
			busy_q       <= 1'b0;
			sign_x_q     <= 1'b0;
			sign_y_q     <= 1'b0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en)
				style_q <= cfg_wr_data;
			if (cmd.load_start) begin
				pos_x_q      <= POS_W'({req.start_x, {FRAC_BITS{1'b0}}});
				pos_y_q      <= POS_W'({req.start_y, {FRAC_BITS{1'b0}}});
				steps_left_q <= steps;
				dash_count_q <= '0;
				dash_off_q   <= 1'b0;
				busy_q       <= (steps != '0);
				sign_x_q     <= dx[COORD_BITS];
				sign_y_q     <= dy[COORD_BITS];
				done_q       <= (steps == '0);
			end else if (cmd.step_adv) begin
				pos_x_q      <= pos_x_q + {{(POS_W-INC_W){inc_x[INC_W-1]}}, inc_x};
				pos_y_q      <= pos_y_q + {{(POS_W-INC_W){inc_y[INC_W-1]}}, inc_y};
				steps_left_q <= steps_left_q - COORD_BITS'(1);
				busy_q       <= ~fin;
				done_q       <= fin;
				if (third) begin
					dash_count_q <= '0;
					dash_off_q   <= ~dash_off_q;
				end else begin
					dash_count_q <= dash_count_q + 2'd1;
				end
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!pix_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Pixel = integer part of position plus the thick offset, wrapped to PIX_W
	logic [SUM_W-1:0] sum_x, sum_y;
	logic signed [1:0] off_x, off_y;

	assign off_x = thick_dx(cmd.pix_idx);
	assign off_y = thick_dy(cmd.pix_idx);
	assign sum_x = SUM_W'(pos_x_q[FRAC_BITS +: COORD_BITS]) + {{(SUM_W-2){off_x[1]}}, off_x};
	assign sum_y = SUM_W'(pos_y_q[FRAC_BITS +: COORD_BITS]) + {{(SUM_W-2){off_y[1]}}, off_y};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.pixel_x   <= sum_x[PIX_W-1:0];
			out_q.pixel_y   <= sum_y[PIX_W-1:0];
			out_q.last      <= cmd.pix_last;
			out_q.line_done <= done_q;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix       = out_q;

endmodule

// ----- rtl/dda_ctrl.sv -----
// Controller: accepts items, sequences pixel emission and waits on the divider.
// Depends on dda_pkg.
module dda_ctrl import dda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      action,
	output logic      req_stall,
	input  dda_stat_t stat,
	output dda_cmd_t  cmd
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             thick_q;
	logic             pend_div_q;
	logic             is_start;

	assign is_start = (action_t'(action) == ACT_START);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (is_start)
						state_d = ST_EMIT;
					else if (stat.busy && stat.adv_emit)
						state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.out_load && cmd.pix_last)
					state_d = pend_div_q ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (!stat.div_busy)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load_start = is_start;
					cmd.step_adv   = ~is_start & stat.busy;
				end
			end
			ST_EMIT: begin
				cmd.out_load = stat.out_free;
				cmd.pix_idx  = thick_q ? idx_q : '0;
				cmd.pix_last = ~thick_q | (idx_q == THICK_LAST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			thick_q    <= 1'b0;
			pend_div_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && req_valid) begin
				idx_q      <= '0;
				thick_q    <= ~is_start & stat.adv_thick;
				pend_div_q <= is_start & ~stat.start_zero;
			end else if (cmd.out_load) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

// ----- rtl/dda_styled_line_generator_top.sv -----
// Styled DDA line generator, top level.
// Request channel (req_valid/req_stall/req) takes start and advance items.
// A start item loads the endpoints, emits the start pixel and runs the
// increment division alongside it; req_stall stays high until the division
// is done. An advance item moves one step along the line and emits 0, 1
// or 9 pixels depending on line_style.
// Pixels leave on (pix_valid/pix_stall/pix) from an output register. An
// accepted item with pixels moves to ST_EMIT, which loads them into that
// register whenever it is free; unless the division is still running, the
// next item is taken the cycle after its last pixel enters that register.
// A pixel-less advance stays in ST_IDLE; one with no active line is dropped.
// The user must write line_style (cfg_wr_en/cfg_wr_data) only while idle; the block does not check.
// When the receiver stalls, the pixel register holds and emission pauses.
// arst_n clears all line state, the style (simple) and the output valid.
// Depends on dda_pkg, dda_ctrl, dda_dp and dda_div.
module dda_styled_line_generator_top import dda_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       req_valid,
	output logic       req_stall,
	input  in_item_t   req,
	output logic       pix_valid,
	input  logic       pix_stall,
	output out_item_t  pix
);

	dda_cmd_t  cmd;
	dda_stat_t stat;

	dda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (req.action),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	dda_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.cmd         (cmd),
		.stat        (stat),
		.pix_stall   (pix_stall),
		.pix_valid   (pix_valid),
		.pix         (pix)
	);

endmodule

// ----- dv/dda_pixel_checker.sv -----
// Pixel checker for the styled DDA line generator: watches the config, request and
// pixel channels, predicts every pixel from accepted items and compares in order.
// Depends on dda_pkg for the item types and style codes.
module dda_pixel_checker import dda_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic      req_valid,
	input  logic      req_stall,
	input  in_item_t  req,
	input  logic      pix_valid,
	input  logic      pix_stall,
	input  out_item_t pix,
	output int        fail_count,
	output int        pending_pixels
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB    = FRAC_BITS_DEF;
	localparam int POS_W = COORD_BITS + FB + 1;
	localparam int INC_W = FB + 2;

	style_t                   style_q;
	bit [POS_W-1:0]           pos_x_q, pos_y_q;
	bit signed [INC_W-1:0]    inc_x_q, inc_y_q;
	bit [COORD_BITS:0]        steps_q;
	bit [1:0]                 dash_q;
	bit                       dash_off_q;
	bit                       active_q;
	out_item_t                pixels_due[$];

	initial begin
		fail_count = 0;
		pending_pixels = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("%0t: pixel mismatch on %s: got %0d, want %0d", $time, what, got, want);
	endtask

	function automatic bit signed [INC_W-1:0] slope(input int d, input int n);
		longint q;
		q = ((d < 0 ? -d : d) * (longint'(1) << FB)) / n;
		return INC_W'(d < 0 ? -q : q);
	endfunction

	// 3x3 block order: center, right, left, down, up, then the four corners
	function automatic void block_offset(input int k, output int ox, output int oy);
		case (k)
			1:       begin ox = 1;  oy = 0;  end
			2:       begin ox = -1; oy = 0;  end
			3:       begin ox = 0;  oy = 1;  end
			4:       begin ox = 0;  oy = -1; end
			5:       begin ox = -1; oy = 1;  end
			6:       begin ox = -1; oy = -1; end
			7:       begin ox = 1;  oy = 1;  end
			8:       begin ox = 1;  oy = -1; end
			default: begin ox = 0;  oy = 0;  end
		endcase
	endfunction

	function automatic void queue_pixel(input int ox, input int oy, input bit lst,
			input bit done);
		out_item_t p;
		p.pixel_x   = PIX_W'(int'(pos_x_q[POS_W-1:FB]) + ox);
		p.pixel_y   = PIX_W'(int'(pos_y_q[POS_W-1:FB]) + oy);
		p.last      = lst;
		p.line_done = done;
		pixels_due.push_back(p);
	endfunction

	function automatic void predict_pixels(input in_item_t it);
		int  dx, dy, n, ox, oy;
		bit  fin, third, was_on, emit;
		if (it.action == ACT_START) begin
			dx = int'(it.end_x) - int'(it.start_x);
			dy = int'(it.end_y) - int'(it.start_y);
			n  = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
				: (dy < 0 ? -dy : dy);
			pos_x_q    = POS_W'(it.start_x) << FB;
			pos_y_q    = POS_W'(it.start_y) << FB;
			dash_q     = 2'd0;
			dash_off_q = 1'b0;
			if (n == 0) begin
				inc_x_q  = '0;
				inc_y_q  = '0;
				steps_q  = '0;
				active_q = 1'b0;
				queue_pixel(0, 0, 1'b1, 1'b1);
			end else begin
				inc_x_q  = slope(dx, n);
				inc_y_q  = slope(dy, n);
				steps_q  = n[COORD_BITS:0];
				active_q = 1'b1;
				queue_pixel(0, 0, 1'b1, 1'b0);
			end
			return;
		end
		if (!active_q)
			return;
		pos_x_q = pos_x_q + POS_W'(inc_x_q);
		pos_y_q = pos_y_q + POS_W'(inc_y_q);
		steps_q = steps_q - 1'b1;
		fin     = (steps_q == 0);
		if (fin)
			active_q = 1'b0;
		third  = (dash_q == 2'd2);
		was_on = !dash_off_q;
		if (third) begin
			dash_q     = 2'd0;
			dash_off_q = !dash_off_q;
		end else begin
			dash_q = dash_q + 1'b1;
		end
		case (style_q)
			STYLE_THICK: begin
				for (int k = 0; k < 9; k++) begin
					block_offset(k, ox, oy);
					queue_pixel(ox, oy, k == 8, fin);
				end
				return;
			end
			STYLE_DOTTED: emit = third || fin;
			STYLE_DASHED: emit = was_on || fin;
			default:      emit = 1'b1;
		endcase
		if (emit)
			queue_pixel(0, 0, 1'b1, fin);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			style_q    = STYLE_SIMPLE;
			pos_x_q    = '0;
			pos_y_q    = '0;
			inc_x_q    = '0;
			inc_y_q    = '0;
			steps_q    = '0;
			dash_q     = '0;
			dash_off_q = 1'b0;
			active_q   = 1'b0;
			pixels_due.delete();
		end else begin
			if (cfg_wr_en)
				style_q = style_t'(cfg_wr_data);
			if (req_valid && !req_stall)
				predict_pixels(req);
			if (pix_valid && !pix_stall) begin
				if (pixels_due.size() == 0) begin
					report_mismatch("unexpected pixel x", int'(pix.pixel_x), 0);
				end else begin
					want = pixels_due.pop_front();
					if (pix.pixel_x !== want.pixel_x)
						report_mismatch("pixel_x", int'(pix.pixel_x), int'(want.pixel_x));
					if (pix.pixel_y !== want.pixel_y)
						report_mismatch("pixel_y", int'(pix.pixel_y), int'(want.pixel_y));
					if (pix.last !== want.last)
						report_mismatch("last", int'(pix.last), int'(want.last));
					if (pix.line_done !== want.line_done)
						report_mismatch("line_done", int'(pix.line_done),
							int'(want.line_done));
				end
			end
		end
	end

	// published away from the rising edge so the stimulus side reads a settled count
	always @(negedge clk)
		pending_pixels = pixels_due.size();

endmodule

// ----- dv/tb.sv -----
// Testbench top for the styled DDA line generator: drives reset, the style register
// and line items with random gaps and pixel stalls; dda_pixel_checker does the checks.
// Depends on dda_pkg, dda_styled_line_generator_top and dda_pixel_checker.
module tb import dda_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 40;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 56;
	localparam int CMAX = (1 << COORD_BITS) - 1;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cfg_wr_en;
	logic [1:0] cfg_wr_data;
	logic      req_valid;
	logic      req_stall;
	in_item_t  req;
	logic      pix_valid;
	logic      pix_stall;
	out_item_t pix;
	int        fail_count;
	int        pending_pixels;

	bit burst_mode;
	bit rx_hold_req;
	int items_done;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dda_styled_line_generator_top uut (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data,
		.req_valid, .req_stall, .req,
		.pix_valid, .pix_stall, .pix
	);

	dda_pixel_checker chk (
		.clk, .arst_n, .cfg_wr_en, .cfg_wr_data,
		.req_valid, .req_stall, .req,
		.pix_valid, .pix_stall, .pix,
		.fail_count, .pending_pixels
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 0;
		if (r < 24)
			return CMAX;
		return $urandom_range(0, CMAX);
	endfunction

	function automatic int near(input int c, input int span);
		int d;
		d = $urandom_range(0, span);
		if ($urandom_range(0, 1))
			d = -d;
		if (c + d < 0 || c + d > CMAX)
			d = -d;
		return c + d;
	endfunction

	function automatic in_item_t start_req(input int x1, input int y1, input int x2,
			input int y2);
		in_item_t it;
		it.action  = ACT_START;
		it.start_x = COORD_BITS'(x1);
		it.start_y = COORD_BITS'(y1);
		it.end_x   = COORD_BITS'(x2);
		it.end_y   = COORD_BITS'(y2);
		return it;
	endfunction

	// coordinates are don't-care on an advance, so they carry random bits
	function automatic in_item_t advance_req();
		in_item_t it;
		it.action  = ACT_ADVANCE;
		it.start_x = COORD_BITS'($urandom);
		it.start_y = COORD_BITS'($urandom);
		it.end_x   = COORD_BITS'($urandom);
		it.end_y   = COORD_BITS'($urandom);
		return it;
	endfunction

	function automatic style_t phase_style(input int p);
		case (p)
			0, 5:    return STYLE_DOTTED;
			1, 4:    return STYLE_DASHED;
			2, 6:    return STYLE_THICK;
			default: return STYLE_SIMPLE;
		endcase
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels != 0)
			@(posedge clk);
		// an advance that emits nothing, or the slope division, may still be running
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_style(input style_t s);
		wait_drained();
		cfg_wr_data <= s;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// one start item, then n advances; advances past the end are not counted
	task automatic draw(input int x1, input int y1, input int x2, input int y2,
			input int n);
		int ax, ay, left;
		ax   = x2 > x1 ? x2 - x1 : x1 - x2;
		ay   = y2 > y1 ? y2 - y1 : y1 - y2;
		left = ax > ay ? ax : ay;
		send_item(start_req(x1, y1, x2, y2));
		items_done++;
		for (int k = 0; k < n; k++) begin
			send_item(advance_req());
			if (left > 0) begin
				left--;
				items_done++;
			end
		end
	endtask

	task automatic random_line();
		int x1, y1, x2, y2, ax, ay, steps, n, r, span;
		x1 = pick_coord();
		y1 = pick_coord();
		r  = $urandom_range(0, 99);
		if (r < 5) begin
			x2 = $urandom_range(0, CMAX);
			y2 = $urandom_range(0, CMAX);
		end else begin
			span = (r < 75) ? 8 : 40;
			x2 = near(x1, span);
			y2 = near(y1, span);
		end
		ax    = x2 > x1 ? x2 - x1 : x1 - x2;
		ay    = y2 > y1 ? y2 - y1 : y1 - y2;
		steps = ax > ay ? ax : ay;
		n     = steps;
		r     = $urandom_range(0, 99);
		if (steps > 40 || r < 8)
			n = $urandom_range(0, steps > 12 ? 12 : steps);
		else if (r < 14)
			n = steps + $urandom_range(1, 2);
		draw(x1, y1, x2, y2, n);
	endtask

	// receiver: short stalls, long free stretches, and one long hold on request
	initial begin : pixel_sink
		int r, free_len, stall_len;
		pix_stall = 1'b0;
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				pix_stall <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end
			r = $urandom_range(0, 99);
			free_len = (r < 70) ? $urandom_range(1, 4)
				: (r < 90) ? $urandom_range(5, 30) : $urandom_range(30, 80);
			r = $urandom_range(0, 99);
			stall_len = (r < 80) ? $urandom_range(1, 2)
				: (r < 95) ? $urandom_range(3, 8) : $urandom_range(15, 40);
			pix_stall <= 1'b0;
			repeat (free_len) @(posedge clk);
			pix_stall <= 1'b1;
			repeat (stall_len) @(posedge clk);
		end
	end

	initial begin : stimulus
		bit paused;
		paused      = 1'b0;
		burst_mode  = 1'b0;
		rx_hold_req = 1'b0;
		items_done  = 0;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 2'd0;
		req_valid   = 1'b0;
		req         = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(advance_req());             // no line yet: dropped
		draw(0, 0, 0, 0, 0);                  // zero length
		draw(CMAX, CMAX, CMAX, CMAX, 0);
		draw(0, 0, 3, 1, 4);                  // one advance past the end
		draw(CMAX, 0, 0, CMAX, 2);            // left busy
		draw(5, 5, 5, 0, 5);                  // restart while busy, negative slope
		draw(CMAX, CMAX, CMAX - 1, CMAX - 3, 3);
		write_style(STYLE_THICK);
		draw(1, 0, 0, 0, 1);                  // block reaches -1
		draw(CMAX - 1, CMAX, CMAX, CMAX, 1);  // block reaches 1024

		for (int p = 0; p < 8; p++) begin
			write_style(phase_style(p));
			burst_mode = ($urandom_range(0, 2) == 0);
			if (p == 2)
				rx_hold_req = 1'b1;
			while (items_done < 25 + (p + 1) * PHASE_ITEMS) begin
				random_line();
				if (p == 4 && !paused && items_done > 25 + 4 * PHASE_ITEMS + 28) begin
					wait_drained();
					paused = 1'b1;
				end
			end
		end

		wait_drained();
		if (fail_count == 0 && pending_pixels == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/dda_pkg.sv
rtl/dda_div.sv
rtl/dda_dp.sv
rtl/dda_ctrl.sv
rtl/dda_styled_line_generator_top.sv
dv/dda_pixel_checker.sv
dv/tb.sv
